// ===== rtl/core/zeckendorf_decompose_macros.svh =====
// ---------------------------------------------------------------------------
// zeckendorf_decompose_macros.svh - assertion helpers
// Shared concurrent-assertion shorthands for the Zeckendorf block.
// ---------------------------------------------------------------------------
`ifndef ZECKENDORF_DECOMPOSE_MACROS_SVH
`define ZECKENDORF_DECOMPOSE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ZD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ZD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/zd_pkg.sv =====
// ---------------------------------------------------------------------------
// zd_pkg - Zeckendorf decomposition package
// Default width, sequencer states and shared-unit opcodes.
// ---------------------------------------------------------------------------
package zd_pkg;

    localparam int ZD_VALUE_BITS = 63;

    typedef enum logic [1:0] {
        ZD_IDLE  = 2'd0,
        ZD_CLIMB = 2'd1,
        ZD_DESC  = 2'd2,
        ZD_STEP  = 2'd3
    } zd_state_t;

    typedef enum logic {
        ZD_OP_ADD = 1'b0,
        ZD_OP_SUB = 1'b1
    } zd_op_t;

endpackage

// ===== rtl/core/zeckendorf_decompose.sv =====
// Operation: input 0 gives its single beat in the cycle after acceptance. Any other value
// first climbs the Fibonacci pair to its largest term, then walks down the term indices,
// testing and subtracting each term; the result side holding m_tready low stalls the descent.
// Throughput: one number at a time; the shared add/subtract unit does one step a cycle unless the result side stalls.
// Reset: aresetn low (synchronous) returns the sequencer to idle, clears the working
// registers and drops m_tvalid.
// ---------------------------------------------------------------------------
// zeckendorf_decompose - greedy Zeckendorf decomposition
// Splits a number into distinct Fibonacci terms, largest first, last marked.
// ---------------------------------------------------------------------------
`include "zeckendorf_decompose_macros.svh"

module zeckendorf_decompose
    import zd_pkg::*;
#(
    parameter int VALUE_BITS = ZD_VALUE_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,  // [VALUE_BITS-1:0] number
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((VALUE_BITS + 7) / 8) * 8-1:0] m_tdata,  // [VALUE_BITS-1:0] term
    output logic                                 m_tlast    // last_term
);

    localparam int W = VALUE_BITS;

    // Sequencer and datapath registers
    zd_state_t      state_reg, state_next;
    logic [W-1:0]   rem_reg,   rem_next;      // remainder (holds the number while climbing)
    logic [W-1:0]   fib_high_reg, fib_high_next;
    logic [W-1:0]   fib_low_reg,  fib_low_next;

    // Output register: parts the sequencer from the downstream stall
    logic           out_valid_reg, out_valid_next;
    logic [W-1:0]   out_term_reg,  out_term_next;
    logic           out_last_reg,  out_last_next;

    // Shared unit
    zd_op_t         alu_op;
    logic [W-1:0]   alu_a, alu_b;
    logic [W:0]     alu_res;

    logic           slot_free;
    logic           s_beat;
    logic [W-1:0]   in_number;
    logic           term_fits;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ZD_IDLE) && slot_free;
    assign s_beat    = s_tvalid && s_tready;
    assign in_number = s_tdata[W-1:0];

    // borrow clear means fib_high <= remainder
    assign term_fits = !alu_res[W];

    zd_alu #(
        .VALUE_BITS (VALUE_BITS)
    ) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res)
    );

    // Operand steering for the shared unit
    always_comb begin
        alu_op = ZD_OP_ADD;
        alu_a  = '0;
        alu_b  = '0;
        case (state_reg)
            ZD_CLIMB: begin      // next term candidate: low + high
                alu_op = ZD_OP_ADD;
                alu_a  = fib_low_reg;
                alu_b  = fib_high_reg;
            end
            ZD_DESC: begin       // test and subtract: rem - high
                alu_op = ZD_OP_SUB;
                alu_a  = rem_reg;
                alu_b  = fib_high_reg;
            end
            ZD_STEP: begin       // term below low: high - low
                alu_op = ZD_OP_SUB;
                alu_a  = fib_high_reg;
                alu_b  = fib_low_reg;
            end
            default: begin
                alu_op = ZD_OP_ADD;
            end
        endcase
    end

    // Next state and datapath
    always_comb begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        fib_high_next  = fib_high_reg;
        fib_low_next   = fib_low_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_term_next  = out_term_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ZD_IDLE: begin
                if (s_beat) begin
                    if (in_number == '0) begin
                        // zero: one beat of value 0, marked last
                        out_valid_next = 1'b1;
                        out_term_next  = '0;
                        out_last_next  = 1'b1;
                    end else if (in_number == W'(1)) begin
                        rem_next      = in_number;
                        fib_high_next = W'(1);
                        fib_low_next  = W'(1);
                        state_next    = ZD_DESC;
                    end else begin
                        rem_next      = in_number;
                        fib_high_next = W'(2);
                        fib_low_next  = W'(1);
                        state_next    = ZD_CLIMB;
                    end
                end
            end
            ZD_CLIMB: begin
                // keep climbing while low + high still fits under the number
                if (alu_res <= {1'b0, rem_reg}) begin
                    fib_low_next  = fib_high_reg;
                    fib_high_next = alu_res[W-1:0];
                end else begin
                    state_next = ZD_DESC;
                end
            end
            ZD_DESC: begin
                if (term_fits) begin
                    if (slot_free) begin
                        rem_next       = alu_res[W-1:0];
                        out_valid_next = 1'b1;
                        out_term_next  = fib_high_reg;
                        out_last_next  = (alu_res[W-1:0] == '0);
                        state_next     = (alu_res[W-1:0] == '0) ? ZD_IDLE : ZD_STEP;
                    end
                end else begin
                    state_next = ZD_STEP;
                end
            end
            ZD_STEP: begin
                fib_high_next = fib_low_reg;
                fib_low_next  = alu_res[W-1:0];
                // sequence exhausted: nothing more to emit
                state_next    = (fib_low_reg == '0) ? ZD_IDLE : ZD_DESC;
            end
            default: begin
                state_next = ZD_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ZD_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg      <= '0;
            fib_high_reg <= '0;
            fib_low_reg  <= '0;
            out_term_reg <= '0;
            out_last_reg <= 1'b0;
        end else begin
            rem_reg      <= rem_next;
            fib_high_reg <= fib_high_next;
            fib_low_reg  <= fib_low_next;
            out_term_reg <= out_term_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        m_tdata         = '0;
        m_tdata[W-1:0]  = out_term_reg;
    end

    // Checks
    `ZD_ASSERT_IMP(a_desc_high_nonzero, aclk, aresetn, state_reg == ZD_DESC, fib_high_reg != '0, "descent with zero term")
    `ZD_ASSERT_IMP(a_fib_order, aclk, aresetn, state_reg != ZD_IDLE, fib_low_reg <= fib_high_reg, "fib pair out of order")
    `ZD_ASSERT_NXT(a_rem_shrinks, aclk, aresetn, state_reg == ZD_DESC && term_fits && slot_free, rem_reg < $past(rem_reg), "remainder did not shrink on emit")
    `ZD_ASSERT_NXT(a_nonzero_starts, aclk, aresetn, s_beat && in_number != '0, state_reg == ZD_CLIMB || state_reg == ZD_DESC, "nonzero input did not start")

endmodule

// ===== rtl/core/zd_alu.sv =====
// ---------------------------------------------------------------------------
// zd_alu - shared add/subtract unit
// One wide adder with a carry/borrow bit; reused by every sequencer step.
// ---------------------------------------------------------------------------
module zd_alu
    import zd_pkg::*;
#(
    parameter int VALUE_BITS = ZD_VALUE_BITS
) (
    input  zd_op_t                op,
    input  logic [VALUE_BITS-1:0] a,
    input  logic [VALUE_BITS-1:0] b,
    output logic [VALUE_BITS:0]   result   // top bit: carry on add, borrow on sub
);

    always_comb begin
        case (op)
            ZD_OP_ADD: result = {1'b0, a} + {1'b0, b};
            ZD_OP_SUB: result = {1'b0, a} - {1'b0, b};
            default:   result = '0;
        endcase
    end

endmodule

// ===== verif/zeckendorf_decompose_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// zeckendorf_decompose_tb - self-checking bench for the Zeckendorf block
// Streams numbers into the block and checks every term beat against a greedy
// decomposition computed here, or against the beat written in a typed table row. A short
// table covers the corner values, and random numbers follow: near-Fibonacci values, zero,
// small values and values of any width. Both streams idle at random, except while calm.
// ---------------------------------------------------------------------------
module zeckendorf_decompose_tb;
    import zd_pkg::*;

    localparam int VB             = ZD_VALUE_BITS;
    localparam int DATA_W         = ((VB + 7) / 8) * 8;
    localparam int MAX_TERMS      = 46;
    localparam int DIRECTED_ROWS  = 17;
    localparam int RANDOM_NUMBERS = 443;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [VB-1:0] term;
        logic          last;
    } term_beat_t;

    // typed == 1: the expected single beat is written in the row itself
    typedef struct packed {
        logic [VB-1:0] number;
        logic          typed;
        logic [VB-1:0] term;
        logic          last;
    } stim_row_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;   // [VB-1:0] number
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;         // [VB-1:0] term
    logic              m_tlast;         // last_term

    term_beat_t term_q[$];
    bit         calm          = 1'b0;   // no idling on either side while set
    int         errors        = 0;
    int         numbers_sent  = 0;
    int         beats_checked = 0;
    int         longest_run   = 0;
    int         idle_cycles   = 0;
    int         ready_stall   = 0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{63'd0,                   1'b1, 63'd0,                   1'b1},
        '{63'd1,                   1'b1, 63'd1,                   1'b1},
        '{63'd2,                   1'b1, 63'd2,                   1'b1},
        '{63'd3,                   1'b1, 63'd3,                   1'b1},
        '{63'd4,                   1'b0, 63'd0,                   1'b0},
        '{63'd12,                  1'b0, 63'd0,                   1'b0},
        '{63'd88,                  1'b0, 63'd0,                   1'b0},
        '{63'd89,                  1'b1, 63'd89,                  1'b1},
        '{63'd144,                 1'b1, 63'd144,                 1'b1},
        '{63'd4660046610375530309, 1'b1, 63'd4660046610375530309, 1'b1},
        // top of the sequence below 2^63
        '{63'd7540113804746346429, 1'b1, 63'd7540113804746346429, 1'b1},
        // one below the top: every other term, 45 beats
        '{63'd7540113804746346428, 1'b0, 63'd0,                   1'b0},
        '{63'd7540113804746346430, 1'b0, 63'd0,                   1'b0},
        '{63'h7FFF_FFFF_FFFF_FFFF, 1'b0, 63'd0,                   1'b0},
        '{63'h5555_5555_5555_5555, 1'b0, 63'd0,                   1'b0},
        '{63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 63'd0,                   1'b0},
        '{63'h4000_0000_0000_0000, 1'b0, 63'd0,                   1'b0}
    };

    zeckendorf_decompose #(
        .VALUE_BITS(VB)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    // Appends one expected beat at the tail of the queue.
    function automatic void expect_term(input term_beat_t beat);
        term_q.insert(term_q.size(), beat);
    endfunction

    // Greedy decomposition: climb to the largest term <= n, then walk down
    // emitting every term that still fits in the remainder.
    function automatic void decompose_number(input logic [VB-1:0] number);
        longint unsigned n;
        longint unsigned rem;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned nxt;
        int              count;
        n     = 64'(number);
        count = 0;
        if (n == 0) begin
            expect_term('{term: '0, last: 1'b1});
            count = 1;
        end else begin
            lo = 1;
            hi = 2;
            if (hi > n) begin
                hi = 1;
                lo = 1;
            end else begin
                while (lo <= n - hi) begin
                    nxt = lo + hi;
                    lo  = hi;
                    hi  = nxt;
                end
            end
            rem = n;
            while (rem != 0 && count < MAX_TERMS) begin
                if (hi <= rem && hi != 0) begin
                    rem -= hi;
                    expect_term('{term: hi[VB-1:0], last: (rem == 0)});
                    count++;
                end
                nxt = hi - lo;
                hi  = lo;
                lo  = nxt;
                if (hi == 0) break;
            end
        end
        if (count > longest_run) longest_run = count;
    endfunction

    // Random number: near a Fibonacci term, zero, small, or any width.
    function automatic logic [VB-1:0] random_number();
        longint unsigned a;
        longint unsigned b;
        longint unsigned t;
        longint unsigned mask;
        int              bits;
        int              r;
        r = $urandom_range(0, 19);
        if (r < 5) begin
            a = 1;
            b = 2;
            repeat ($urandom_range(0, 91)) begin
                t = a + b;
                a = b;
                b = t;
            end
            return VB'(a + $urandom_range(0, 2) - 1);
        end
        if (r == 5) return '0;
        bits = (r < 10) ? $urandom_range(1, 16) : $urandom_range(1, VB);
        mask = (64'd1 << bits) - 1;
        return VB'({$urandom, $urandom} & mask);
    endfunction

    // Holds tvalid across back-to-back beats; returns at the accepting edge.
    task automatic send_number(input logic [VB-1:0] number, input logic typed,
                               input term_beat_t typed_beat);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(number);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (typed) begin
            expect_term(typed_beat);
            if (longest_run == 0) longest_run = 1;
        end else begin
            decompose_number(number);
        end
        numbers_sent++;
    endtask

    // Sender holds off until every outstanding term has come back.
    task automatic drain_terms();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (term_q.size() != 0) @(posedge aclk);
    endtask

    task automatic check_beat();
        term_beat_t want;
        if (term_q.size() == 0) begin
            $display("%0t: unexpected beat, term=%0d last=%0b", $time,
                     m_tdata[VB-1:0], m_tlast);
            errors++;
        end else begin
            want = term_q.pop_front();
            if (m_tdata[VB-1:0] !== want.term) begin
                $display("%0t: term mismatch, expected %0d, got %0d", $time,
                         want.term, m_tdata[VB-1:0]);
                errors++;
            end
            if (m_tlast !== want.last) begin
                $display("%0t: tlast mismatch, expected %0b, got %0b", $time,
                         want.last, m_tlast);
                errors++;
            end
            beats_checked++;
        end
    endtask

    // Result side: check accepted beats, drive tready with random stalls.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) check_beat();
            if (ready_stall > 0) begin
                ready_stall--;
                m_tready <= 1'b0;
            end else begin
                ready_stall = pick_gap();
                m_tready <= (ready_stall == 0);
                if (ready_stall > 0) ready_stall--;
            end
        end
    end

    // Watchdog: too long without a beat on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d terms outstanding", $time,
                         idle_cycles, term_q.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int i;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corner values, 0 first right out of reset
        for (i = 0; i < DIRECTED_ROWS; i++) begin
            send_number(directed_rows[i].number, directed_rows[i].typed,
                        '{term: directed_rows[i].term, last: directed_rows[i].last});
        end
        drain_terms();

        // random part, with stretches of no idling and the odd full drain
        for (i = 0; i < RANDOM_NUMBERS; i++) begin
            calm = (((i / 40) % 3) == 1);
            send_number(random_number(), 1'b0, '0);
            if ($urandom_range(0, 49) == 0) drain_terms();
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (term_q.size() != 0) @(posedge aclk);
        // nothing further may come out once the last term has arrived
        repeat (20) @(posedge aclk);

        $display("Decomposed %0d numbers (%0d from the corner table), %0d term beats checked.",
                 numbers_sent, DIRECTED_ROWS, beats_checked);
        $display("Longest decomposition %0d terms; %0d mismatches.", longest_run, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
